// File: design/mbpq_pkg.sv
// Shared types and constants for the max bucket priority queue.
// Holds the command codes, status codes, controller states and defaults.
// No dependencies.
package mbpq_pkg;

  // Default sizes handed to the top level
  localparam int NumItemsDef     = 4096;
  localparam int NumDistancesDef = 256;

  // Request and result field widths
  localparam int CmdW    = 2;
  localparam int ItemW   = 12;
  localparam int DistW   = 8;
  localparam int StatusW = 3;

  // Packed stream widths, rounded up to whole bytes
  localparam int InBits   = CmdW + ItemW + DistW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;
  localparam int OutBits  = StatusW + ItemW + DistW;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  // Command decode: bit 1 set means clear, otherwise pop or push
  localparam logic [CmdW-1:0] CmdPush     = 2'd0;
  localparam logic [CmdW-1:0] CmdPop      = 2'd1;
  localparam int              CmdClearBit = 1;

  typedef enum logic [StatusW-1:0] {
    ST_PUSHED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_POPPED    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,   // sweep memories after reset
    S_IDLE,   // take a request
    S_PUSH,   // item mark and bucket head are read back
    S_HEAD,   // bucket head is read back, scan down on empty
    S_LINK,   // link of the popped item is read back
    S_CLEAR,  // sweep memories for a clear request
    S_DONE    // result waits for the output register
  } state_e;

endpackage

// File: design/max_bucket_priority_queue_top.sv
// Max bucket priority queue: top level with controller and two tables.
// Depends on mbpq_pkg and mbpq_ram.
//
// Usage:
//   Requests enter on the s_axis channel, one command each: push an item
//   under a distance, pop the newest item of the largest non-empty
//   distance, or clear the queue. Every request yields exactly one result
//   on the m_axis channel (status, popped item, popped distance).
//   A push reads the item mark and bucket head, then links the item in; a
//   pop reads the bucket head, walking the head table down one bucket per
//   cycle past empty buckets, then reads the link of the popped item. A
//   pop on a queue marked empty and a push of an out-of-range item
//   finish as they are accepted. A clear writes one entry of each table per cycle.
//   After reset the block sweeps every entry of both tables with
//   s_axis_tready_o low; no result is produced.
//   A result sits in an output register; the next request is taken while it
//   waits. If the receiver stalls and a second result is ready, it is held
//   and no further request is taken until the output register drains.
module max_bucket_priority_queue_top #(
  parameter int NUM_ITEMS     = mbpq_pkg::NumItemsDef,
  parameter int NUM_DISTANCES = mbpq_pkg::NumDistancesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // command [1:0], item_index [13:2], distance [21:14], zero [23:22]
  input  logic [mbpq_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status [2:0], popped_item [14:3], popped_distance [22:15], zero [23]
  output logic [mbpq_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int IW    = $clog2(NUM_ITEMS);
  localparam int DW    = $clog2(NUM_DISTANCES);
  localparam int Sweep = (NUM_ITEMS > NUM_DISTANCES) ? NUM_ITEMS : NUM_DISTANCES;
  localparam int CW    = $clog2(Sweep);
  localparam int HW    = IW + 1;   // head entry: valid, index
  localparam int EW    = IW + 2;   // item entry: mark, link valid, link index

  // Request fields
  logic [mbpq_pkg::CmdW-1:0]  in_cmd;
  logic [mbpq_pkg::ItemW-1:0] in_item;
  logic [mbpq_pkg::DistW-1:0] in_dist;
  logic                       in_fire;
  logic                       in_item_bad;
  logic [DW-1:0]              in_dist_sat;

  assign in_cmd  = s_axis_tdata_i[mbpq_pkg::CmdW-1:0];
  assign in_item = s_axis_tdata_i[mbpq_pkg::CmdW +: mbpq_pkg::ItemW];
  assign in_dist = s_axis_tdata_i[mbpq_pkg::CmdW + mbpq_pkg::ItemW +: mbpq_pkg::DistW];

  assign in_item_bad = (32'(in_item) >= NUM_ITEMS);
  assign in_dist_sat = (32'(in_dist) >= NUM_DISTANCES) ? DW'(NUM_DISTANCES - 1)
                                                        : DW'(in_dist);

  // Controller registers
  mbpq_pkg::state_e state_q, state_d;
  logic [DW-1:0]    top_q, top_d;
  logic             any_q, any_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    item_q, item_d;
  logic [DW-1:0]    dist_q, dist_d;

  // Held result while the output register is busy
  mbpq_pkg::status_e          res_status_q, res_status_d;
  logic [mbpq_pkg::ItemW-1:0] res_item_q, res_item_d;
  logic [mbpq_pkg::DistW-1:0] res_dist_q, res_dist_d;

  // Output register
  logic                       out_valid_q;
  mbpq_pkg::status_e          out_status_q;
  logic [mbpq_pkg::ItemW-1:0] out_item_q;
  logic [mbpq_pkg::DistW-1:0] out_dist_q;
  logic                       out_free;
  logic                       out_load;

  // Result finished this cycle
  logic                       fin;
  mbpq_pkg::status_e          fin_status;
  logic [mbpq_pkg::ItemW-1:0] fin_item;
  logic [mbpq_pkg::DistW-1:0] fin_dist;

  // Table ports
  logic          h_we, i_we;
  logic [DW-1:0] h_waddr, h_raddr;
  logic [IW-1:0] i_waddr, i_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic [EW-1:0] i_wdata, i_rdata;

  logic sweep_last;
  logic cnt_in_heads;
  logic cnt_in_items;

  assign sweep_last   = (cnt_q == CW'(Sweep - 1));
  assign cnt_in_heads = ({1'b0, cnt_q} < (CW + 1)'(NUM_DISTANCES));
  assign cnt_in_items = ({1'b0, cnt_q} < (CW + 1)'(NUM_ITEMS));

  assign s_axis_tready_o = (state_q == mbpq_pkg::S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  mbpq_ram #(
    .Depth(NUM_DISTANCES),
    .Width(HW)
  ) u_heads (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  mbpq_ram #(
    .Depth(NUM_ITEMS),
    .Width(EW)
  ) u_items (
    .clk_i  (clk_i),
    .we_i   (i_we),
    .waddr_i(i_waddr),
    .wdata_i(i_wdata),
    .raddr_i(i_raddr),
    .rdata_o(i_rdata)
  );

  // Datapath and table control per state
  always_comb begin
    top_d      = top_q;
    any_d      = any_q;
    cnt_d      = cnt_q;
    item_d     = item_q;
    dist_d     = dist_q;
    fin        = 1'b0;
    fin_status = mbpq_pkg::ST_PUSHED;
    fin_item   = '0;
    fin_dist   = '0;
    h_we       = 1'b0;
    h_waddr    = dist_q;
    h_wdata    = '0;
    h_raddr    = top_q;
    i_we       = 1'b0;
    i_waddr    = item_q;
    i_wdata    = '0;
    i_raddr    = item_q;

    unique case (state_q) inside
      mbpq_pkg::S_INIT, mbpq_pkg::S_CLEAR: begin
        // Zero one entry of each table per cycle
        h_we    = cnt_in_heads;
        h_waddr = cnt_q[DW-1:0];
        i_we    = cnt_in_items;
        i_waddr = cnt_q[IW-1:0];
        cnt_d   = sweep_last ? '0 : CW'(cnt_q + 1'b1);
        if (sweep_last && (state_q == mbpq_pkg::S_CLEAR)) begin
          fin        = 1'b1;
          fin_status = mbpq_pkg::ST_CLEARED;
        end
      end

      mbpq_pkg::S_IDLE: begin
        // Latch the request and start the table reads
        item_d  = IW'(in_item);
        dist_d  = in_dist_sat;
        i_raddr = IW'(in_item);
        h_raddr = (in_cmd == mbpq_pkg::CmdPop) ? top_q : in_dist_sat;
        if (in_fire) begin
          if (in_cmd[mbpq_pkg::CmdClearBit]) begin
            top_d = '0;
            any_d = 1'b0;
            cnt_d = '0;
          end else if (in_cmd == mbpq_pkg::CmdPop) begin
            if (!any_q) begin
              fin        = 1'b1;
              fin_status = mbpq_pkg::ST_EMPTY;
              top_d      = '0;
            end
          end else if (in_item_bad) begin
            fin        = 1'b1;
            fin_status = mbpq_pkg::ST_DUPLICATE;
          end
        end
      end

      mbpq_pkg::S_PUSH: begin
        // Link the item in front of the old head unless already queued
        fin = 1'b1;
        if (i_rdata[EW-1]) begin
          fin_status = mbpq_pkg::ST_DUPLICATE;
        end else begin
          fin_status = mbpq_pkg::ST_PUSHED;
          h_we       = 1'b1;
          h_waddr    = dist_q;
          h_wdata    = {1'b1, item_q};
          i_we       = 1'b1;
          i_waddr    = item_q;
          i_wdata    = {1'b1, h_rdata};
          if (!any_q || (dist_q > top_q)) begin
            top_d = dist_q;
            any_d = 1'b1;
          end
        end
      end

      mbpq_pkg::S_HEAD: begin
        // Take the head, or step down past an empty bucket
        if (h_rdata[HW-1]) begin
          item_d  = h_rdata[IW-1:0];
          i_raddr = h_rdata[IW-1:0];
        end else if (top_q == '0) begin
          any_d      = 1'b0;
          fin        = 1'b1;
          fin_status = mbpq_pkg::ST_EMPTY;
        end else begin
          top_d   = DW'(top_q - 1'b1);
          h_raddr = DW'(top_q - 1'b1);
        end
      end

      mbpq_pkg::S_LINK: begin
        // Unlink the head and drop its mark
        h_we       = 1'b1;
        h_waddr    = top_q;
        h_wdata    = i_rdata[HW-1:0];
        i_we       = 1'b1;
        i_waddr    = item_q;
        i_wdata    = '0;
        fin        = 1'b1;
        fin_status = mbpq_pkg::ST_POPPED;
        fin_item   = mbpq_pkg::ItemW'(item_q);
        fin_dist   = mbpq_pkg::DistW'(top_q);
      end

      mbpq_pkg::S_DONE: begin
        // Result held in res registers
      end

      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      mbpq_pkg::S_INIT: begin
        if (sweep_last) state_d = mbpq_pkg::S_IDLE;
      end
      mbpq_pkg::S_IDLE: begin
        if (in_fire) begin
          if (fin) begin
            state_d = out_free ? mbpq_pkg::S_IDLE : mbpq_pkg::S_DONE;
          end else if (in_cmd[mbpq_pkg::CmdClearBit]) begin
            state_d = mbpq_pkg::S_CLEAR;
          end else if (in_cmd == mbpq_pkg::CmdPop) begin
            state_d = mbpq_pkg::S_HEAD;
          end else begin
            state_d = mbpq_pkg::S_PUSH;
          end
        end
      end
      mbpq_pkg::S_HEAD: begin
        if (fin) begin
          state_d = out_free ? mbpq_pkg::S_IDLE : mbpq_pkg::S_DONE;
        end else if (h_rdata[HW-1]) begin
          state_d = mbpq_pkg::S_LINK;
        end
      end
      mbpq_pkg::S_PUSH, mbpq_pkg::S_LINK, mbpq_pkg::S_CLEAR: begin
        if (fin) begin
          state_d = out_free ? mbpq_pkg::S_IDLE : mbpq_pkg::S_DONE;
        end
      end
      mbpq_pkg::S_DONE: begin
        if (out_free) state_d = mbpq_pkg::S_IDLE;
      end
      default: state_d = mbpq_pkg::S_INIT;
    endcase
  end

  // Hold a finished result until the output register frees up
  always_comb begin
    res_status_d = res_status_q;
    res_item_d   = res_item_q;
    res_dist_d   = res_dist_q;
    if (fin && !out_free) begin
      res_status_d = fin_status;
      res_item_d   = fin_item;
      res_dist_d   = fin_dist;
    end
  end

  assign out_load = out_free && (fin || (state_q == mbpq_pkg::S_DONE));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbpq_pkg::S_INIT;
      top_q       <= '0;
      any_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      any_q   <= any_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    dist_q       <= dist_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    res_dist_q   <= res_dist_d;
    if (out_load) begin
      if (state_q == mbpq_pkg::S_DONE) begin
        out_status_q <= res_status_q;
        out_item_q   <= res_item_q;
        out_dist_q   <= res_dist_q;
      end else begin
        out_status_q <= fin_status;
        out_item_q   <= fin_item;
        out_dist_q   <= fin_dist;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mbpq_pkg::OutDataW'({out_dist_q, out_item_q, out_status_q});

  // Checks
  a_idle_top_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (top_q == '0))
    else $error("top bucket bound set while queue marked empty");

  a_top_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) < NUM_DISTANCES)
    else $error("top bucket bound out of range");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbpq_pkg::S_DONE) |-> out_valid_q)
    else $error("result held while output register is free");

  a_sweep_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mbpq_pkg::S_INIT && state_q != mbpq_pkg::S_CLEAR) |-> (cnt_q == '0))
    else $error("sweep counter not at zero outside a sweep");

endmodule

// File: design/mbpq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the bucket head table and the per-item link and mark table.
// Depends on nothing.
module mbpq_ram #(
  parameter int Depth = 256,
  parameter int Width = 13
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sim/max_bucket_priority_queue_top_test.sv
// Self-checking testbench for the max bucket priority queue top level.
// Streams push, pop and clear requests, predicts each result, and checks it.
// Depends on mbpq_pkg and the design sources under design.
`timescale 1ns / 1ps

module max_bucket_priority_queue_top_test;

  localparam int NumItems     = mbpq_pkg::NumItemsDef;
  localparam int NumDistances = mbpq_pkg::NumDistancesDef;
  localparam int RandomReqs   = 1850;
  localparam int IdleLimit    = 20000;
  localparam int DrainCycles  = 300;

  // Bit 1 set decodes as clear, so both codes empty the queue
  localparam logic [mbpq_pkg::CmdW-1:0] CmdClear   = 2'd2;
  localparam logic [mbpq_pkg::CmdW-1:0] CmdClearHi = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE   // ready about a quarter of the time
  } rx_mode_e;

  typedef struct packed {
    logic [mbpq_pkg::CmdW-1:0]  cmd;
    logic [mbpq_pkg::ItemW-1:0] item;
    logic [mbpq_pkg::DistW-1:0] distance;
  } queue_req_t;

  typedef struct packed {
    mbpq_pkg::status_e          status;
    logic [mbpq_pkg::ItemW-1:0] item;
    logic [mbpq_pkg::DistW-1:0] distance;
  } queue_res_t;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          s_valid  = 1'b0;
  logic                          s_ready;
  logic [mbpq_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                          m_valid;
  logic                          m_ready  = 1'b0;
  logic [mbpq_pkg::OutDataW-1:0] m_tdata;

  max_bucket_priority_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the queue: bucket heads and links carry a valid bit on top
  logic [mbpq_pkg::ItemW:0] bkt_head    [NumDistances];
  logic [mbpq_pkg::ItemW:0] item_link   [NumItems];
  logic                     item_queued [NumItems];
  int                       top_bkt;
  logic                     top_known;

  queue_req_t cmd_backlog[$];
  queue_res_t queue_outcomes[$];

  int n_requests;
  int n_accepted;
  int n_errors;
  int n_status [5];

  function automatic void drop_all_buckets();
    foreach (bkt_head[i]) bkt_head[i] = '0;
    foreach (item_queued[i]) item_queued[i] = 1'b0;
    top_bkt   = 0;
    top_known = 1'b0;
  endfunction

  // Apply one request to the shadow queue and return its result
  function automatic void apply_queue_cmd(input queue_req_t rq, output queue_res_t rs);
    int                       b;
    int                       d;
    logic [mbpq_pkg::ItemW:0] head;
    rs = '{status: mbpq_pkg::ST_EMPTY, item: '0, distance: '0};
    if (rq.cmd[mbpq_pkg::CmdClearBit]) begin
      drop_all_buckets();
      rs.status = mbpq_pkg::ST_CLEARED;
    end else if (rq.cmd == mbpq_pkg::CmdPop) begin
      // Walk down from the bound until a non-empty bucket turns up
      while (top_known && rs.status != mbpq_pkg::ST_POPPED) begin
        b = (top_bkt >= NumDistances) ? NumDistances - 1 : top_bkt;
        top_bkt = b;
        head = bkt_head[b];
        if (!head[mbpq_pkg::ItemW]) begin
          if (b == 0) begin
            top_known = 1'b0;
            top_bkt   = 0;
          end else begin
            top_bkt = b - 1;
          end
        end else begin
          bkt_head[b] = item_link[head[mbpq_pkg::ItemW-1:0]];
          item_link[head[mbpq_pkg::ItemW-1:0]]   = '0;
          item_queued[head[mbpq_pkg::ItemW-1:0]] = 1'b0;
          rs.item     = head[mbpq_pkg::ItemW-1:0];
          rs.distance = mbpq_pkg::DistW'(b);
          rs.status   = mbpq_pkg::ST_POPPED;
        end
      end
      if (rs.status == mbpq_pkg::ST_EMPTY) top_bkt = 0;
    end else begin
      d = (int'(rq.distance) >= NumDistances) ? NumDistances - 1 : int'(rq.distance);
      if (int'(rq.item) >= NumItems || item_queued[rq.item]) begin
        rs.status = mbpq_pkg::ST_DUPLICATE;
      end else begin
        item_link[rq.item]   = bkt_head[d];
        bkt_head[d]          = {1'b1, rq.item};
        item_queued[rq.item] = 1'b1;
        if (!top_known || d > top_bkt) begin
          top_bkt   = d;
          top_known = 1'b1;
        end
        rs.status = mbpq_pkg::ST_PUSHED;
      end
    end
  endfunction

  task automatic add_req(input logic [mbpq_pkg::CmdW-1:0] cmd, input int item,
                         input int distance);
    cmd_backlog.push_back('{cmd: cmd, item: mbpq_pkg::ItemW'(item),
                            distance: mbpq_pkg::DistW'(distance)});
  endtask

  // Sender: bursts of requests separated by random gaps
  queue_req_t cur_req;
  queue_res_t drv_res;
  int         burst_left = 1;
  int         gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        apply_queue_cmd(cur_req, drv_res);
        queue_outcomes.push_back(drv_res);
        n_accepted++;
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0 || cmd_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_valid <= 1'b0;
        end else begin
          cur_req = cmd_backlog.pop_front();
          s_valid <= 1'b1;
          s_tdata <= mbpq_pkg::InDataW'({cur_req.distance, cur_req.item, cur_req.cmd});
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  // Receiver: ready pattern picks a new random mode after each random span
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_span = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_span = $urandom_range(8, 64);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        RX_OPEN: begin
          m_ready <= 1'b1;
        end
        RX_COIN: begin
          m_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Check each result against the oldest prediction
  queue_res_t mon_exp;
  queue_res_t mon_got;

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      mon_got.status   = mbpq_pkg::status_e'(m_tdata[mbpq_pkg::StatusW-1:0]);
      mon_got.item     = m_tdata[mbpq_pkg::StatusW +: mbpq_pkg::ItemW];
      mon_got.distance = m_tdata[mbpq_pkg::StatusW + mbpq_pkg::ItemW +: mbpq_pkg::DistW];
      if (queue_outcomes.size() == 0) begin
        $error("unexpected result: status %0d item %0d distance %0d",
               mon_got.status, mon_got.item, mon_got.distance);
        n_errors++;
      end else begin
        mon_exp = queue_outcomes.pop_front();
        if (int'(mon_got.status) < 5) n_status[mon_got.status]++;
        if (mon_got.status !== mon_exp.status) begin
          $error("status: expected %0d actual %0d", mon_exp.status, mon_got.status);
          n_errors++;
        end
        if (mon_got.item !== mon_exp.item) begin
          $error("popped_item: expected %0d actual %0d", mon_exp.item, mon_got.item);
          n_errors++;
        end
        if (mon_got.distance !== mon_exp.distance) begin
          $error("popped_distance: expected %0d actual %0d",
                 mon_exp.distance, mon_got.distance);
          n_errors++;
        end
      end
    end
  end

  // Abort when neither side moves for too long
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sel;
    int n;
    int n_pops;
    int narrow_pool;
    int dist_mode;
    int dist_base;
    int d;

    n_accepted = 0;
    n_errors   = 0;
    foreach (n_status[i]) n_status[i] = 0;
    foreach (item_link[i]) item_link[i] = '0;
    drop_all_buckets();

    // Directed: extremes, duplicates, LIFO order, scan down, both clear codes
    add_req(mbpq_pkg::CmdPop,  4095, 255);
    add_req(mbpq_pkg::CmdPush, 0,    0);
    add_req(mbpq_pkg::CmdPush, 4095, 255);
    add_req(mbpq_pkg::CmdPush, 4095, 3);
    add_req(mbpq_pkg::CmdPush, 2730, 255);
    add_req(mbpq_pkg::CmdPush, 1365, 170);
    add_req(mbpq_pkg::CmdPush, 0,    85);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPop,  1365, 85);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPush, 4095, 255);
    add_req(mbpq_pkg::CmdPush, 17,   1);
    add_req(CmdClearHi,        4095, 255);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPush, 4095, 0);
    add_req(mbpq_pkg::CmdPush, 2048, 128);
    add_req(CmdClear,          2048, 128);
    add_req(mbpq_pkg::CmdPush, 5,    200);
    add_req(mbpq_pkg::CmdPop,  0,    0);
    add_req(mbpq_pkg::CmdPop,  0,    0);

    // Random: mostly push runs followed by pops, some noise, rare clears
    while (cmd_backlog.size() < RandomReqs + 22) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        add_req($urandom_range(0, 1) ? CmdClear : CmdClearHi,
                $urandom_range(0, 4095), $urandom_range(0, 255));
      end else if (sel < 75) begin
        n           = $urandom_range(1, 12);
        n_pops      = n + $urandom_range(0, 2);
        narrow_pool = $urandom_range(0, 2);
        dist_mode   = $urandom_range(0, 2);
        dist_base   = $urandom_range(0, 252);
        for (int i = 0; i < n; i++) begin
          case (dist_mode)
            0:       d = $urandom_range(0, 255);
            1:       d = dist_base + $urandom_range(0, 3);
            default: d = $urandom_range(0, 1) ? 255 : 0;
          endcase
          add_req(mbpq_pkg::CmdPush, (narrow_pool == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 4095), d);
          // Interleave some pops into the push run
          if (n_pops > 0 && $urandom_range(0, 4) == 0) begin
            add_req(mbpq_pkg::CmdPop, $urandom_range(0, 4095), $urandom_range(0, 255));
            n_pops--;
          end
        end
        for (int i = 0; i < n_pops; i++) begin
          add_req(mbpq_pkg::CmdPop, $urandom_range(0, 4095), $urandom_range(0, 255));
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          add_req($urandom_range(0, 1) ? mbpq_pkg::CmdPop : mbpq_pkg::CmdPush,
                  $urandom_range(0, 4095), $urandom_range(0, 255));
        end
      end
    end
    n_requests = cmd_backlog.size();

    // Hold reset, then release at a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every result has arrived
    @(negedge clk_i);
    while (n_accepted < n_requests || queue_outcomes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d requests: %0d pushed, %0d duplicates, %0d popped,",
             n_requests, n_status[mbpq_pkg::ST_PUSHED],
             n_status[mbpq_pkg::ST_DUPLICATE], n_status[mbpq_pkg::ST_POPPED]);
    $display("  %0d pops on an empty queue, %0d clears, %0d mismatches",
             n_status[mbpq_pkg::ST_EMPTY], n_status[mbpq_pkg::ST_CLEARED], n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
